@@ src/ssb_pkg.sv @@
// ----------------------------------------------------------------------------
// ssb_pkg: shared types and constants
// Opcodes, status selectors, flag bit positions, I/O page addresses and the
// decoded request record that passes between the soft switch bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

   typedef enum logic [1:0] {
      OP_READ       = 2'd0,
      OP_WRITE      = 2'd1,
      OP_SET_PADDLE = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      SS_NONE       = 4'h0,
      SS_LC_BANK2   = 4'h1,
      SS_LC_READ    = 4'h2,
      SS_RAMRD      = 4'h3,
      SS_RAMWRT     = 4'h4,
      SS_INTCXROM   = 4'h5,
      SS_ALTZP      = 4'h6,
      SS_SLOTC3ROM  = 4'h7,
      SS_80STORE    = 4'h8,
      SS_VBLANK_N   = 4'h9,
      SS_TEXT       = 4'hA,
      SS_MIXED      = 4'hB,
      SS_PAGE2      = 4'hC,
      SS_HIRES      = 4'hD,
      SS_ALTCHAR    = 4'hE,
      SS_80COL      = 4'hF
   } stat_sel_type;

   localparam int MM_W = 6;
   localparam int DF_W = 7;

   localparam logic [2:0] MM_80STORE   = 3'd0;
   localparam logic [2:0] MM_RAMRD     = 3'd1;
   localparam logic [2:0] MM_RAMWRT    = 3'd2;
   localparam logic [2:0] MM_INTCXROM  = 3'd3;
   localparam logic [2:0] MM_ALTZP     = 3'd4;
   localparam logic [2:0] MM_SLOTC3ROM = 3'd5;

   localparam logic [2:0] DF_TEXT    = 3'd0;
   localparam logic [2:0] DF_MIXED   = 3'd1;
   localparam logic [2:0] DF_PAGE2   = 3'd2;
   localparam logic [2:0] DF_HIRES   = 3'd3;
   localparam logic [2:0] DF_80COL   = 3'd4;
   localparam logic [2:0] DF_ALTCHAR = 3'd5;
   localparam logic [2:0] DF_DHIRES  = 3'd6;

   localparam logic [15:0] ADDR_MM_LO       = 16'hC000;
   localparam logic [15:0] ADDR_MM_HI       = 16'hC00B;
   localparam logic [15:0] ADDR_COLCHAR_LO  = 16'hC00C;
   localparam logic [15:0] ADDR_80COL_HI    = 16'hC00D;
   localparam logic [15:0] ADDR_COLCHAR_HI  = 16'hC00F;
   localparam logic [15:0] ADDR_STATUS_LO   = 16'hC011;
   localparam logic [15:0] ADDR_STATUS_HI   = 16'hC01F;
   localparam logic [15:0] ADDR_DISP_LO     = 16'hC050;
   localparam logic [15:0] ADDR_BANK_LO     = 16'hC054;
   localparam logic [15:0] ADDR_DISP_HI     = 16'hC057;
   localparam logic [15:0] ADDR_DHIRES_SET  = 16'hC05E;
   localparam logic [15:0] ADDR_DHIRES_CLR  = 16'hC05F;
   localparam logic [15:0] ADDR_PADDLE_BASE = 16'hC064;
   localparam logic [15:0] ADDR_PTRIG       = 16'hC070;

   localparam logic [7:0] CPU_RESET = 8'd11;

   typedef struct packed {
      logic         is_read;
      logic         mm_wr;
      logic [2:0]   mm_bit;
      logic         disp_wr;
      logic [2:0]   disp_bit;
      logic         flag_val;
      logic         status;
      stat_sel_type stat_sel;
      logic         trig;
      logic         paddle_rd;
      logic [1:0]   paddle_idx;
      logic         set_paddle;
      logic [1:0]   set_axis;
      logic         bank;
   } dec_type;

   typedef struct packed {
      logic lc_bank2;
      logic lc_read_ram;
      logic in_vblank;
   } stat_in_type;

endpackage

`default_nettype wire

@@ src/ssb_if.sv @@
// ----------------------------------------------------------------------------
// ssb_if: request, response and register write channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] address;
   logic [6:0]  key_bits;
   logic        lc_bank2;
   logic        lc_read_ram;
   logic        in_vblank;
   logic [31:0] cycle_now;
   logic [1:0]  axis;
   logic [7:0]  position;

   modport source (output valid, opcode, address, key_bits, lc_bank2, lc_read_ram,
                   in_vblank, cycle_now, axis, position, input ready);
   modport sink (input valid, opcode, address, key_bits, lc_bank2, lc_read_ram,
                 in_vblank, cycle_now, axis, position, output ready);
endinterface

interface ssb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       banking_changed;

   modport source (output valid, read_data, banking_changed, input ready);
   modport sink (input valid, read_data, banking_changed, output ready);
endinterface

interface ssb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] cycles_per_unit;

   modport source (output valid, cycles_per_unit, input ready);
   modport sink (input valid, cycles_per_unit, output ready);
endinterface

`default_nettype wire

@@ src/ssb_decode.sv @@
// ----------------------------------------------------------------------------
// ssb_decode: I/O page address decoder
// Turns one registered request into switch, status and paddle selects.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_decode #(
   parameter int AXIS_COUNT = 4
) (
   input  wire logic [1:0]      opcode,
   input  wire logic [15:0]     address,
   input  wire logic [1:0]      axis,
   output ssb_pkg::dec_type     dec
);
   import ssb_pkg::*;

   logic        is_read;
   logic        is_write;
   logic        in_mm;
   logic        acc;
   logic        in_colchar;
   logic        in_disp;
   logic        in_dhires;
   logic [16:0] paddle_end;
   logic [15:0] paddle_off;

   assign is_read    = opcode == OP_READ;
   assign is_write   = opcode == OP_WRITE;
   assign in_mm      = address >= ADDR_MM_LO && address <= ADDR_MM_HI;
   assign acc        = is_read || (is_write && !in_mm);
   assign in_colchar = address >= ADDR_COLCHAR_LO && address <= ADDR_COLCHAR_HI;
   assign in_disp    = address >= ADDR_DISP_LO && address <= ADDR_DISP_HI;
   assign in_dhires  = address == ADDR_DHIRES_SET || address == ADDR_DHIRES_CLR;
   assign paddle_end = {1'b0, ADDR_PADDLE_BASE} + 17'(AXIS_COUNT);
   assign paddle_off = address - ADDR_PADDLE_BASE;

   always_comb begin
      dec            = '0;
      dec.is_read    = is_read;
      dec.mm_wr      = is_write && in_mm;
      dec.mm_bit     = address[3:1];
      dec.disp_wr    = acc && (in_colchar || in_disp || in_dhires);
      dec.flag_val   = address[0];
      priority if (in_colchar) begin
         dec.disp_bit = (address <= ADDR_80COL_HI) ? DF_80COL : DF_ALTCHAR;
      end else if (in_disp) begin
         dec.disp_bit = {1'b0, address[2:1]};
      end else begin
         dec.disp_bit = DF_DHIRES;
         if (in_dhires) begin
            dec.flag_val = address == ADDR_DHIRES_SET;
         end
      end
      dec.status     = is_read && address >= ADDR_STATUS_LO && address <= ADDR_STATUS_HI;
      dec.stat_sel   = stat_sel_type'(address[3:0]);
      dec.trig       = acc && address == ADDR_PTRIG;
      dec.paddle_rd  = is_read && address >= ADDR_PADDLE_BASE
                       && {1'b0, address} < paddle_end;
      dec.paddle_idx = paddle_off[1:0];
      dec.set_paddle = opcode == OP_SET_PADDLE && {30'b0, axis} < 32'(AXIS_COUNT);
      dec.set_axis   = axis;
      dec.bank       = acc && ((address >= ADDR_BANK_LO && address <= ADDR_DISP_HI)
                       || in_dhires);
   end

endmodule

`default_nettype wire

@@ src/ssb_flags.sv @@
// ----------------------------------------------------------------------------
// ssb_flags: memory map and display flag registers
// Holds the soft switch flags and selects the status bit for $C011-$C01F.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_flags (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire ssb_pkg::dec_type      dec,
   input  wire ssb_pkg::stat_in_type  stat_in,
   output logic                       status_bit
);
   import ssb_pkg::*;

   logic [MM_W-1:0] mm_ff;
   logic [MM_W-1:0] mm_in;
   logic [DF_W-1:0] df_ff;
   logic [DF_W-1:0] df_in;

   always_comb begin
      mm_in = mm_ff;
      df_in = df_ff;
      if (advance && dec.mm_wr) begin
         mm_in[dec.mm_bit] = dec.flag_val;
      end
      if (advance && dec.disp_wr) begin
         df_in[dec.disp_bit] = dec.flag_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff <= '0;
         df_ff <= '0;
      end else begin
         mm_ff <= mm_in;
         df_ff <= df_in;
      end
   end

   always_comb begin
      unique case (dec.stat_sel)
         SS_LC_BANK2:  status_bit = stat_in.lc_bank2;
         SS_LC_READ:   status_bit = stat_in.lc_read_ram;
         SS_RAMRD:     status_bit = mm_ff[MM_RAMRD];
         SS_RAMWRT:    status_bit = mm_ff[MM_RAMWRT];
         SS_INTCXROM:  status_bit = mm_ff[MM_INTCXROM];
         SS_ALTZP:     status_bit = mm_ff[MM_ALTZP];
         SS_SLOTC3ROM: status_bit = mm_ff[MM_SLOTC3ROM];
         SS_80STORE:   status_bit = mm_ff[MM_80STORE];
         SS_VBLANK_N:  status_bit = !stat_in.in_vblank;
         SS_TEXT:      status_bit = df_ff[DF_TEXT];
         SS_MIXED:     status_bit = df_ff[DF_MIXED];
         SS_PAGE2:     status_bit = df_ff[DF_PAGE2];
         SS_HIRES:     status_bit = df_ff[DF_HIRES];
         SS_ALTCHAR:   status_bit = df_ff[DF_ALTCHAR];
         SS_80COL:     status_bit = df_ff[DF_80COL];
         default:      status_bit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

@@ src/ssb_paddle.sv @@
// ----------------------------------------------------------------------------
// ssb_paddle: game port paddle timer
// Holds paddle positions, the trigger cycle and cycles per unit, and compares
// elapsed cycles against position times cycles per unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_paddle #(
   parameter int AXIS_COUNT    = 4,
   parameter int CYCLE_WIDTH   = 32,
   parameter int PADDLE_CENTER = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire ssb_pkg::dec_type  dec,
   input  wire logic [31:0]       cycle_now,
   input  wire logic [7:0]        position,
   input  wire logic              csr_write,
   input  wire logic [7:0]        csr_data,
   output logic                   paddle_high
);
   import ssb_pkg::*;

   localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   logic [7:0]             pos_ff [AXIS_COUNT];
   logic [CYCLE_WIDTH-1:0] trig_ff;
   logic [7:0]             cpu_ff;
   logic [63:0]            now_ext;
   logic [CYCLE_WIDTH-1:0] now_w;
   logic [CYCLE_WIDTH-1:0] elapsed;
   logic [15:0]            span;

   assign now_ext     = {32'b0, cycle_now};
   assign now_w       = now_ext[CYCLE_WIDTH-1:0];
   assign elapsed     = now_w - trig_ff;
   assign span        = pos_ff[dec.paddle_idx[IDX_W-1:0]] * cpu_ff;
   assign paddle_high = elapsed < CYCLE_WIDTH'(span);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            pos_ff[i] <= 8'(PADDLE_CENTER);
         end
         trig_ff <= '0;
         cpu_ff  <= CPU_RESET;
      end else begin
         if (advance && dec.set_paddle) begin
            pos_ff[dec.set_axis[IDX_W-1:0]] <= position;
         end
         if (advance && dec.trig) begin
            trig_ff <= now_w;
         end
         if (csr_write) begin
            cpu_ff <= csr_data;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/soft_switch_bank_paddle_timer_core.sv @@
// ----------------------------------------------------------------------------
// soft_switch_bank_paddle_timer_core: soft switch bank and paddle timer
// Decodes I/O page bus requests, keeps memory map and display flags, answers
// status and paddle reads, and arms the paddle one-shots.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   opcode address key_bits lc_* in_vblank
//                               cycle_now axis position
//   rsp_ch   out  valid/ready   read_data banking_changed
//   csr_ch   in   valid/ready   cycles_per_unit
//
// One request per cycle while the response is not stalled; a request passes
// an input register, then decode, flag update and the paddle compare into the
// response register. Flag and paddle state change as a request enters the
// response register. Reset needs no clearing pass. A stalled response
// holds the input register, which then deasserts ready.
// Register writes are taken in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_switch_bank_paddle_timer_core #(
   parameter int AXIS_COUNT    = 4,
   parameter int CYCLE_WIDTH   = 32,
   parameter int PADDLE_CENTER = 128
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ssb_req_if.sink     req_ch,
   ssb_rsp_if.source   rsp_ch,
   ssb_csr_if.sink     csr_ch
);
   import ssb_pkg::*;

   logic        s1_valid_ff;
   logic [1:0]  s1_opcode_ff;
   logic [15:0] s1_address_ff;
   logic [6:0]  s1_key_ff;
   stat_in_type s1_stat_ff;
   logic [31:0] s1_cycle_ff;
   logic [1:0]  s1_axis_ff;
   logic [7:0]  s1_position_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic [7:0]  rsp_data_in;
   logic        rsp_bank_ff;

   logic        advance;
   logic        req_fire;
   dec_type     dec;
   logic        status_bit;
   logic        paddle_high;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = rsp_data_ff;
   assign rsp_ch.banking_changed = rsp_bank_ff;

   ssb_decode #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_decode (
      .opcode  (s1_opcode_ff),
      .address (s1_address_ff),
      .axis    (s1_axis_ff),
      .dec     (dec)
   );

   ssb_flags u_flags (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .dec        (dec),
      .stat_in    (s1_stat_ff),
      .status_bit (status_bit)
   );

   ssb_paddle #(
      .AXIS_COUNT    (AXIS_COUNT),
      .CYCLE_WIDTH   (CYCLE_WIDTH),
      .PADDLE_CENTER (PADDLE_CENTER)
   ) u_paddle (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .dec         (dec),
      .cycle_now   (s1_cycle_ff),
      .position    (s1_position_ff),
      .csr_write   (csr_ch.valid && csr_ch.ready),
      .csr_data    (csr_ch.cycles_per_unit),
      .paddle_high (paddle_high)
   );

   always_comb begin
      priority if (dec.status) begin
         rsp_data_in = {status_bit, s1_key_ff};
      end else if (dec.paddle_rd) begin
         rsp_data_in = {paddle_high, 7'b0};
      end else begin
         rsp_data_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff   <= req_ch.opcode;
         s1_address_ff  <= req_ch.address;
         s1_key_ff      <= req_ch.key_bits;
         s1_stat_ff     <= '{lc_bank2: req_ch.lc_bank2, lc_read_ram: req_ch.lc_read_ram,
                             in_vblank: req_ch.in_vblank};
         s1_cycle_ff    <= req_ch.cycle_now;
         s1_axis_ff     <= req_ch.axis;
         s1_position_ff <= req_ch.position;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_bank_ff <= dec.bank;
      end
   end

   a_bank_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bank_ff |-> rsp_data_ff == 8'h00)
      else $error("banking response carries nonzero read data");

   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      advance && s1_opcode_ff == OP_WRITE |=> rsp_data_ff == 8'h00)
      else $error("write request produced read data");

   a_full_stage_moves: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_valid_ff |-> advance)
      else $error("request taken while input register could not drain");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ tb/sv/soft_switch_bank_paddle_timer_core_test.sv @@
// ----------------------------------------------------------------------------
// soft_switch_bank_paddle_timer_core_test: self-checking bench for the core
// Sends bus reads, bus writes and paddle updates through the request channel.
// A scoreboard predicts each response from its own copy of the switch flags,
// paddle positions, trigger cycle and cycles_per_unit, but pinned directed
// rows expect the response given in the table. It runs the directed rows, then
// six random phases, each with a register setting and a mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module soft_switch_bank_paddle_timer_core_test;
   import ssb_pkg::*;

   localparam int AXIS_COUNT    = 4;
   localparam int CYCLE_WIDTH   = 32;
   localparam int PADDLE_CENTER = 128;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 180;
   localparam int DIRECTED_ROWS = 26;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [6:0]  key_bits;
      logic        lc_bank2;
      logic        lc_read_ram;
      logic        in_vblank;
      logic [31:0] cycle_now;
      logic [1:0]  axis;
      logic [7:0]  position;
   } access_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       banking_changed;
   } bus_rsp_type;

   typedef struct packed {
      access_type acc;
      logic       pinned;
      logic [7:0] read_data;
      logic       banking_changed;
   } dir_row_type;

   logic clock;
   logic reset;

   ssb_req_if req_ch();
   ssb_rsp_if rsp_ch();
   ssb_csr_if csr_ch();

   soft_switch_bank_paddle_timer_core #(
      .AXIS_COUNT(AXIS_COUNT),
      .CYCLE_WIDTH(CYCLE_WIDTH),
      .PADDLE_CENTER(PADDLE_CENTER)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   logic [MM_W-1:0] map_flags;
   logic [DF_W-1:0] video_flags;
   logic [7:0]      paddle_pos [AXIS_COUNT];
   logic [31:0]     trigger_at;
   logic [7:0]      unit_cycles;
   logic [31:0]     bus_cycle;

   logic        pinned_row;
   bus_rsp_type pinned_rsp;

   bus_rsp_type expected_responses [$];
   int       mismatch_count;
   int       requests_sent;
   int       responses_checked;
   int       high_reads;
   int       bank_hits;
   int       cycle_count;
   int       send_gap_pct;
   int       stall_pct;

   int gap_mix   [PHASES] = '{0, 66, 0, 12, 0, 66};
   int stall_mix [PHASES] = '{0, 0, 66, 12, 66, 0};

   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{OP_READ, 16'hC01A, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC019, 7'h7F, 1'b0, 1'b0, 1'b0, 32'h0, 2'd0, 8'h00}, 1'b1, 8'hFF, 1'b0},
      '{'{OP_READ, 16'hC064, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h80, 1'b0},
      '{'{OP_WRITE, 16'hC001, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC018, 7'h55, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_WRITE, 16'hC00B, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC017, 7'h2A, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC000, 7'h7F, 1'b1, 1'b1, 1'b0, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC011, 7'h00, 1'b1, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h80, 1'b0},
      '{'{OP_READ, 16'hC012, 7'h00, 1'b0, 1'b1, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h80, 1'b0},
      '{'{OP_WRITE, 16'hC055, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b1},
      '{'{OP_READ, 16'hC01C, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC05E, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b1},
      '{'{OP_READ, 16'hC00D, 7'h00, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC01F, 7'h01, 1'b0, 1'b0, 1'b1, 32'h0, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_WRITE, 16'hC070, 7'h00, 1'b0, 1'b0, 1'b1, 32'hFFFFFFF0, 2'd0, 8'h00},
         1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC066, 7'h00, 1'b0, 1'b0, 1'b1, 32'h10, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_SET_PADDLE, 16'h0000, 7'h00, 1'b0, 1'b0, 1'b1, 32'h10, 2'd1, 8'h02},
         1'b1, 8'h00, 1'b0},
      '{'{OP_WRITE, 16'hC070, 7'h00, 1'b0, 1'b0, 1'b1, 32'd100, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC065, 7'h00, 1'b0, 1'b0, 1'b1, 32'd121, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC065, 7'h00, 1'b0, 1'b0, 1'b1, 32'd122, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_SET_PADDLE, 16'hFFFF, 7'h7F, 1'b1, 1'b1, 1'b1, 32'd122, 2'd3, 8'h00},
         1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hC067, 7'h00, 1'b0, 1'b0, 1'b1, 32'd122, 2'd0, 8'h00}, 1'b0, 8'h00, 1'b0},
      '{'{OP_RESERVED, 16'hC05F, 7'h7F, 1'b1, 1'b1, 1'b0, 32'h0, 2'd3, 8'hFF},
         1'b1, 8'h00, 1'b0},
      '{'{OP_READ, 16'hFFFF, 7'h7F, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 2'd0, 8'h00},
         1'b1, 8'h00, 1'b0},
      '{'{OP_WRITE, 16'hC01C, 7'h7F, 1'b1, 1'b1, 1'b0, 32'h0, 2'd0, 8'h00}, 1'b1, 8'h00, 1'b0}
   };

   function automatic bus_rsp_type switch_bank_response(input access_type a);
      bus_rsp_type r;
      logic        flag;
      logic        via_access;
      logic [31:0] elapsed;
      logic [15:0] span;
      r = '0;
      flag = 1'b0;
      via_access = (a.opcode == OP_READ) || (a.opcode == OP_WRITE &&
                   !(a.address >= ADDR_MM_LO && a.address <= ADDR_MM_HI));
      if (a.opcode == OP_SET_PADDLE) begin
         if (a.axis < AXIS_COUNT) paddle_pos[a.axis] = a.position;
      end else if (a.opcode == OP_WRITE && !via_access) begin
         map_flags[a.address[3:1]] = a.address[0];
      end else if (via_access) begin
         if (a.address >= ADDR_STATUS_LO && a.address <= ADDR_STATUS_HI) begin
            case (stat_sel_type'(a.address[3:0]))
               SS_LC_BANK2:  flag = a.lc_bank2;
               SS_LC_READ:   flag = a.lc_read_ram;
               SS_RAMRD:     flag = map_flags[MM_RAMRD];
               SS_RAMWRT:    flag = map_flags[MM_RAMWRT];
               SS_INTCXROM:  flag = map_flags[MM_INTCXROM];
               SS_ALTZP:     flag = map_flags[MM_ALTZP];
               SS_SLOTC3ROM: flag = map_flags[MM_SLOTC3ROM];
               SS_80STORE:   flag = map_flags[MM_80STORE];
               SS_VBLANK_N:  flag = !a.in_vblank;
               SS_TEXT:      flag = video_flags[DF_TEXT];
               SS_MIXED:     flag = video_flags[DF_MIXED];
               SS_PAGE2:     flag = video_flags[DF_PAGE2];
               SS_HIRES:     flag = video_flags[DF_HIRES];
               SS_ALTCHAR:   flag = video_flags[DF_ALTCHAR];
               SS_80COL:     flag = video_flags[DF_80COL];
               default:      flag = 1'b0;
            endcase
            r.read_data = {flag, a.key_bits};
         end else if (a.address == ADDR_PTRIG) begin
            trigger_at = a.cycle_now;
         end else if (a.address >= ADDR_PADDLE_BASE &&
                      a.address < ADDR_PADDLE_BASE + AXIS_COUNT) begin
            elapsed = a.cycle_now - trigger_at;
            span = 16'(paddle_pos[a.address[1:0]]) * 16'(unit_cycles);
            r.read_data = (elapsed < 32'(span)) ? 8'h80 : 8'h00;
         end else if (a.address >= ADDR_COLCHAR_LO && a.address <= ADDR_COLCHAR_HI) begin
            video_flags[a.address[1] ? DF_ALTCHAR : DF_80COL] = a.address[0];
         end else if (a.address >= ADDR_DISP_LO && a.address <= ADDR_DISP_HI) begin
            video_flags[a.address[2:1]] = a.address[0];
         end else if (a.address == ADDR_DHIRES_SET || a.address == ADDR_DHIRES_CLR) begin
            video_flags[DF_DHIRES] = (a.address == ADDR_DHIRES_SET);
         end
         r.banking_changed = (a.address >= ADDR_BANK_LO && a.address <= ADDR_DISP_HI) ||
                             a.address == ADDR_DHIRES_SET || a.address == ADDR_DHIRES_CLR;
         if (a.opcode == OP_WRITE) r.read_data = 8'h00;
      end
      return r;
   endfunction

   function automatic access_type random_access();
      access_type a;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 45) a.opcode = OP_READ;
      else if (pick < 75) a.opcode = OP_WRITE;
      else if (pick < 95) a.opcode = OP_SET_PADDLE;
      else a.opcode = OP_RESERVED;
      pick = $urandom_range(99);
      if (pick < 10) a.address = 16'($urandom);
      else if (pick < 30) a.address = ADDR_PADDLE_BASE + 16'($urandom_range(AXIS_COUNT - 1));
      else if (pick < 40) a.address = ADDR_PTRIG;
      else a.address = ADDR_MM_LO + 16'($urandom_range(127));
      a.key_bits = 7'($urandom);
      a.lc_bank2 = 1'($urandom);
      a.lc_read_ram = 1'($urandom);
      a.in_vblank = 1'($urandom);
      if ($urandom_range(99) < 3) bus_cycle = $urandom;
      else bus_cycle = bus_cycle + $urandom_range(32 * unit_cycles + 8);
      a.cycle_now = bus_cycle;
      a.axis = 2'($urandom);
      pick = $urandom_range(9);
      a.position = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      return a;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("response %0d: %s", responses_checked, msg);
   endtask

   task automatic send_request(input access_type a, input logic pin,
                               input bus_rsp_type pin_rsp);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= a.opcode;
      req_ch.address     <= a.address;
      req_ch.key_bits    <= a.key_bits;
      req_ch.lc_bank2    <= a.lc_bank2;
      req_ch.lc_read_ram <= a.lc_read_ram;
      req_ch.in_vblank   <= a.in_vblank;
      req_ch.cycle_now   <= a.cycle_now;
      req_ch.axis        <= a.axis;
      req_ch.position    <= a.position;
      pinned_row         <= pin;
      pinned_rsp         <= pin_rsp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   task automatic write_cycles_per_unit(input logic [7:0] value);
      csr_ch.valid           <= 1'b1;
      csr_ch.cycles_per_unit <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      unit_cycles = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin : score_responses
      bus_rsp_type want;
      access_type  seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected response read_data 0x%02h bank %0b",
                                         rsp_ch.read_data, rsp_ch.banking_changed));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_ch.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data expected 0x%02h, got 0x%02h",
                                            want.read_data, rsp_ch.read_data));
               if (rsp_ch.banking_changed !== want.banking_changed)
                  report_mismatch($sformatf("banking_changed expected %0b, got %0b",
                                            want.banking_changed, rsp_ch.banking_changed));
            end
            if (rsp_ch.read_data[7] === 1'b1) high_reads++;
            if (rsp_ch.banking_changed === 1'b1) bank_hits++;
            responses_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            seen = '{req_ch.opcode, req_ch.address, req_ch.key_bits, req_ch.lc_bank2,
                     req_ch.lc_read_ram, req_ch.in_vblank, req_ch.cycle_now, req_ch.axis,
                     req_ch.position};
            want = switch_bank_response(seen);
            if (pinned_row) want = pinned_rsp;
            expected_responses.push_back(want);
         end
      end
   end

   initial begin
      access_type item;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_READ;
      req_ch.address = '0;
      req_ch.key_bits = '0;
      req_ch.lc_bank2 = 1'b0;
      req_ch.lc_read_ram = 1'b0;
      req_ch.in_vblank = 1'b0;
      req_ch.cycle_now = '0;
      req_ch.axis = '0;
      req_ch.position = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.cycles_per_unit = '0;
      pinned_row = 1'b0;
      pinned_rsp = '0;
      map_flags = '0;
      video_flags = '0;
      for (int k = 0; k < AXIS_COUNT; k++) paddle_pos[k] = 8'(PADDLE_CENTER);
      trigger_at = '0;
      unit_cycles = CPU_RESET;
      bus_cycle = '0;
      mismatch_count = 0;
      requests_sent = 0;
      responses_checked = 0;
      high_reads = 0;
      bank_hits = 0;
      cycle_count = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_request(directed_rows[r].acc, directed_rows[r].pinned,
                      {directed_rows[r].read_data, directed_rows[r].banking_changed});
      bus_cycle = 32'd200;

      for (int p = 0; p < PHASES; p++) begin
         send_gap_pct = gap_mix[p];
         stall_pct = stall_mix[p];
         if (p != 0) begin
            drain_responses();
            case (p)
               1:       write_cycles_per_unit(8'd1);
               2:       write_cycles_per_unit(8'd255);
               3:       write_cycles_per_unit(8'd0);
               default: write_cycles_per_unit(8'($urandom_range(2, 254)));
            endcase
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off until the pipeline is empty
            if (i == PHASE_ITEMS / 2) drain_responses();
            item = random_access();
            send_request(item, 1'b0, '0);
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses (%0d with bit 7 high, %0d bank changes)",
               requests_sent, responses_checked, high_reads, bank_hits);
      $display("cycles_per_unit covered 11, 1, 255, 0 and random; gaps and stalls up to 66%%");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ soft_switch_bank_paddle_timer_core.f @@
src/ssb_pkg.sv
src/ssb_if.sv
src/ssb_decode.sv
src/ssb_flags.sv
src/ssb_paddle.sv
src/soft_switch_bank_paddle_timer_core.sv
tb/sv/soft_switch_bank_paddle_timer_core_test.sv
